/* rtl/core/clcd_pkg.sv */
// Shared types, codes and helper functions for the character LCD bus sequencer.
package clcd_pkg;

    // Host request codes carried in req_type.
    localparam logic [2:0] REQ_NONE     = 3'd0;
    localparam logic [2:0] REQ_CMD_WR   = 3'd1;
    localparam logic [2:0] REQ_DATA_WR  = 3'd2;
    localparam logic [2:0] REQ_DATA_RD  = 3'd3;
    localparam logic [2:0] REQ_STAT_RD  = 3'd4;
    localparam logic [2:0] REQ_POWERUP  = 3'd5;

    // Configuration register indexes.
    localparam logic [2:0] CFG_E_HIGH   = 3'd0;
    localparam logic [2:0] CFG_TICKS_MS = 3'd1;
    localparam logic [2:0] CFG_FUNC_SET = 3'd2;
    localparam logic [2:0] CFG_ENTRY    = 3'd3;
    localparam logic [2:0] CFG_DISP     = 3'd4;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int WAIT_W     = 23;
    localparam int STEP_W     = 4;

    // Register reset values.
    localparam logic [7:0]  E_HIGH_RST   = 8'd25;
    localparam logic [15:0] TICKS_MS_RST = 16'd50000;
    localparam logic [7:0]  FUNC_SET_RST = 8'h2C;
    localparam logic [7:0]  ENTRY_RST    = 8'h06;
    localparam logic [7:0]  DISP_RST     = 8'h0E;

    localparam logic [7:0] BUSY_FLAG  = 8'h80;
    localparam logic [7:0] CLEAR_CMD  = 8'h01;
    localparam logic [3:0] RAW_NIB_3  = 4'h3;
    localparam logic [3:0] RAW_NIB_2  = 4'h2;

    // Power-up step numbers that need special handling.
    localparam logic [STEP_W-1:0] STEP_FIRST_WAIT = 4'd0;
    localparam logic [STEP_W-1:0] STEP_SHORT_WAIT = 4'd2;
    localparam logic [STEP_W-1:0] STEP_LAST_WAIT  = 4'd8;
    localparam logic [STEP_W-1:0] STEP_LAST_RAW   = 4'd7;
    localparam logic [STEP_W-1:0] STEP_FUNC_SET   = 4'd9;
    localparam logic [STEP_W-1:0] STEP_ENTRY      = 4'd10;
    localparam logic [STEP_W-1:0] STEP_CLEAR      = 4'd11;
    localparam logic [STEP_W-1:0] STEP_LAST_CMD   = 4'd12;

    localparam logic [WAIT_W-1:0] MS_LONG  = 23'd100;
    localparam logic [WAIT_W-1:0] MS_SHORT = 23'd5;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_WAIT     = 4'd1,
        PH_RAW_E    = 4'd2,
        PH_RAW_GAP  = 4'd3,
        PH_WR_E     = 4'd4,
        PH_WR_GAP   = 4'd5,
        PH_RD_E     = 4'd6,
        PH_RD_GAP   = 4'd7,
        PH_POLL_E   = 4'd8,
        PH_POLL_GAP = 4'd9
    } phase_t;

    typedef struct packed {
        logic [7:0]  e_high_ticks;
        logic [15:0] ticks_per_ms;
        logic [7:0]  function_set_word;
        logic [7:0]  entry_mode_word;
        logic [7:0]  display_control_word;
    } cfg_t;

    // What starting one power-up step does to the sequencer.
    typedef struct packed {
        phase_t              phase;
        logic [WAIT_W-1:0]   wait_cnt;
        logic                held_load;
        logic [7:0]          held;
        logic                lnn_clear;
        logic                fin;
    } step_t;

    typedef struct packed {
        logic       lcd_e;
        logic       lcd_rs;
        logic       lcd_rw;
        logic       lcd_bus_drive;
        logic [3:0] lcd_bus_out;
        logic       ready_res;
        logic       done_res;
        logic [7:0] read_byte;
        logic       rejected;
    } res_t;

    function automatic logic [3:0] rev4(input logic [3:0] n);
        return {n[0], n[1], n[2], n[3]};
    endfunction

    // E high count, zero acts as one.
    function automatic logic [WAIT_W-1:0] e_load(input logic [7:0] e_ticks);
        return (e_ticks == 8'd0) ? WAIT_W'(1) : WAIT_W'(e_ticks);
    endfunction

    function automatic step_t start_step(input logic [STEP_W-1:0] s, input cfg_t cfg);
        step_t             r;
        logic [WAIT_W-1:0] ms;
        logic [WAIT_W-1:0] n;
        r.phase     = PH_IDLE;
        r.wait_cnt  = e_load(cfg.e_high_ticks);
        r.held_load = 1'b0;
        r.held      = CLEAR_CMD;
        r.lnn_clear = 1'b0;
        r.fin       = 1'b0;
        ms = (s == STEP_FIRST_WAIT) ? MS_LONG :
             (s == STEP_SHORT_WAIT) ? MS_SHORT : WAIT_W'(1);
        n  = ms * WAIT_W'(cfg.ticks_per_ms);
        if (s <= STEP_LAST_WAIT && !s[0])
        begin
            r.phase    = PH_WAIT;
            r.wait_cnt = (n == '0) ? WAIT_W'(1) : n;
        end
        else if (s <= STEP_LAST_RAW)
        begin
            r.phase = PH_RAW_E;
        end
        else if (s <= STEP_LAST_CMD)
        begin
            r.phase     = PH_WR_E;
            r.held_load = 1'b1;
            r.lnn_clear = 1'b1;
            r.held      = (s == STEP_FUNC_SET) ? cfg.function_set_word :
                          (s == STEP_ENTRY)    ? cfg.entry_mode_word :
                          (s == STEP_CLEAR)    ? CLEAR_CMD : cfg.display_control_word;
        end
        else
        begin
            r.fin = 1'b1;
        end
        return r;
    endfunction

endpackage

/* rtl/core/clcd_if.sv */
// Request and result channel interfaces for the character LCD bus sequencer.
interface clcd_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] req_type;
    logic [7:0] req_byte;
    logic [3:0] bus_in;

    modport source (output valid, req_type, req_byte, bus_in, input ready);
    modport sink   (input valid, req_type, req_byte, bus_in, output ready);
endinterface

interface clcd_res_if;
    logic       valid;
    logic       ready;
    logic       lcd_e;
    logic       lcd_rs;
    logic       lcd_rw;
    logic       lcd_bus_drive;
    logic [3:0] lcd_bus_out;
    logic       ready_res;
    logic       done_res;
    logic [7:0] read_byte;
    logic       rejected;

    modport source (output valid, lcd_e, lcd_rs, lcd_rw, lcd_bus_drive, lcd_bus_out,
                    ready_res, done_res, read_byte, rejected, input ready);
    modport sink   (input valid, lcd_e, lcd_rs, lcd_rw, lcd_bus_drive, lcd_bus_out,
                    ready_res, done_res, read_byte, rejected, output ready);
endinterface

/* rtl/core/char_lcd_4bit_bus_sequencer_unit.sv */
// Top level of the character LCD 4-bit bus sequencer.
//
// Usage:
//   req  : one beat per clock tick of the LCD pin sequencer. req_type asks for a
//          command write, data write, data read, status read or the power-up
//          sequence; bus_in is the raw nibble on the LCD data pins that tick.
//   res  : one beat for every req beat: pin levels (E, RS, RW, drive, nibble),
//          ready/done/rejected flags and the byte read.
//   cfg  : cfg_we/cfg_index/cfg_data write the E width, ticks per ms and the
//          three power-up command words; write only while the sequencer idles.
// Output: a res beat is registered and appears in the cycle after its req beat is taken.
// Throughput: one beat per cycle while the receiver drains res; the sequencer state and
//   the result register are updated together in the same cycle, so back-to-back beats flow freely.
// Stall: res holds its beat in an output register; req.ready stays high while
//   that register is empty or being drained, so a stalled receiver stops
//   intake after one beat and nothing is lost.
// Reset: the sequencer goes idle, the result register empties and the config
//   registers return to their defaults (E width 25, 50000 ticks/ms, 0x2C,
//   0x06, 0x0E). Busy polling has no timeout.
module char_lcd_4bit_bus_sequencer_unit
    import clcd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    clcd_req_if.sink              req,
    clcd_res_if.source            res
);

    // Config registers
    cfg_t cfg_reg;

    // Sequencer state
    phase_t            phase_reg, phase_next;
    logic [WAIT_W-1:0] wait_reg, wait_next;
    logic [7:0]        held_reg, held_next;
    logic [7:0]        asm_reg, asm_next;
    logic [2:0]        kind_reg, kind_next;
    logic [STEP_W-1:0] pstep_reg, pstep_next;
    logic              lnn_reg, lnn_next;

    // Result register
    logic res_valid_reg, res_valid_next;
    res_t res_reg, res_next;

    logic              req_fire;
    logic              req_known;
    logic              kind_rs;
    logic [STEP_W-1:0] step_sel;
    step_t             st;
    logic [3:0]        rd_nib;
    logic [7:0]        sampled;

    // Intake runs whenever the result register can take a beat.
    assign req.ready = !res_valid_reg || res.ready;
    assign req_fire  = req.valid && req.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.e_high_ticks         <= E_HIGH_RST;
            cfg_reg.ticks_per_ms         <= TICKS_MS_RST;
            cfg_reg.function_set_word    <= FUNC_SET_RST;
            cfg_reg.entry_mode_word      <= ENTRY_RST;
            cfg_reg.display_control_word <= DISP_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_E_HIGH:   cfg_reg.e_high_ticks         <= cfg_data[7:0];
                CFG_TICKS_MS: cfg_reg.ticks_per_ms         <= cfg_data;
                CFG_FUNC_SET: cfg_reg.function_set_word    <= cfg_data[7:0];
                CFG_ENTRY:    cfg_reg.entry_mode_word      <= cfg_data[7:0];
                CFG_DISP:     cfg_reg.display_control_word <= cfg_data[7:0];
                default: ;    // indexes past the list are dropped
            endcase
        end
    end

    // One shared step decoder: step 0 from idle, otherwise the following step.
    assign step_sel = (phase_reg == PH_IDLE) ? STEP_FIRST_WAIT : pstep_reg + 4'd1;
    assign st       = start_step(step_sel, cfg_reg);

    assign req_known = (req.req_type >= REQ_CMD_WR) && (req.req_type <= REQ_POWERUP);
    assign kind_rs   = (kind_reg == REQ_DATA_WR) || (kind_reg == REQ_DATA_RD);

    // Read nibble: high half first, then low half.
    assign rd_nib  = rev4(req.bus_in);
    assign sampled = lnn_reg ? {asm_reg[7:4], rd_nib} : {rd_nib, 4'h0};

    always_comb
    begin
        phase_next = phase_reg;
        wait_next  = wait_reg;
        held_next  = held_reg;
        asm_next   = asm_reg;
        kind_next  = kind_reg;
        pstep_next = pstep_reg;
        lnn_next   = lnn_reg;
        res_next   = '0;

        // Pin levels for this tick
        unique case (phase_reg)
            PH_RAW_E:
            begin
                res_next.lcd_e         = 1'b1;
                res_next.lcd_bus_drive = 1'b1;
                res_next.lcd_bus_out   = rev4((pstep_reg == STEP_LAST_RAW) ?
                                              RAW_NIB_2 : RAW_NIB_3);
            end
            PH_WR_E:
            begin
                res_next.lcd_e         = 1'b1;
                res_next.lcd_rs        = kind_rs;
                res_next.lcd_bus_drive = 1'b1;
                res_next.lcd_bus_out   = rev4(lnn_reg ? held_reg[3:0] : held_reg[7:4]);
            end
            PH_WR_GAP:
            begin
                res_next.lcd_rs = kind_rs;
            end
            PH_RD_E:
            begin
                res_next.lcd_e  = 1'b1;
                res_next.lcd_rs = kind_rs;
                res_next.lcd_rw = 1'b1;
            end
            PH_RD_GAP:
            begin
                res_next.lcd_rs = kind_rs;
                res_next.lcd_rw = 1'b1;
            end
            PH_POLL_E:
            begin
                res_next.lcd_e  = 1'b1;
                res_next.lcd_rw = 1'b1;
            end
            PH_POLL_GAP:
            begin
                res_next.lcd_rw = 1'b1;
            end
            default: ;
        endcase

        // Sequencing
        unique case (phase_reg)
            PH_IDLE:
            begin
                res_next.ready_res = 1'b1;
                if (req_known)
                begin
                    kind_next = req.req_type;
                    lnn_next  = 1'b0;
                    if (req.req_type == REQ_CMD_WR || req.req_type == REQ_DATA_WR)
                    begin
                        held_next  = req.req_byte;
                        phase_next = PH_WR_E;
                        wait_next  = e_load(cfg_reg.e_high_ticks);
                    end
                    else if (req.req_type == REQ_DATA_RD || req.req_type == REQ_STAT_RD)
                    begin
                        phase_next = PH_RD_E;
                        wait_next  = e_load(cfg_reg.e_high_ticks);
                    end
                    else
                    begin
                        pstep_next = STEP_FIRST_WAIT;
                        phase_next = st.phase;
                        wait_next  = st.wait_cnt;
                    end
                end
            end
            PH_WAIT, PH_RAW_GAP:
            begin
                if (phase_reg == PH_WAIT && wait_reg > WAIT_W'(1))
                begin
                    wait_next = wait_reg - WAIT_W'(1);
                end
                else
                begin
                    pstep_next        = step_sel;
                    phase_next        = st.phase;
                    wait_next         = st.fin ? wait_reg : st.wait_cnt;
                    res_next.done_res = st.fin;
                    if (st.held_load)
                    begin
                        held_next = st.held;
                    end
                    if (st.lnn_clear)
                    begin
                        lnn_next = 1'b0;
                    end
                end
            end
            PH_RAW_E, PH_WR_E:
            begin
                if (wait_reg > WAIT_W'(1))
                begin
                    wait_next = wait_reg - WAIT_W'(1);
                end
                else
                begin
                    phase_next = (phase_reg == PH_RAW_E) ? PH_RAW_GAP : PH_WR_GAP;
                end
            end
            PH_WR_GAP:
            begin
                lnn_next   = 1'b1;
                phase_next = lnn_reg ? PH_POLL_E : PH_WR_E;
                wait_next  = e_load(cfg_reg.e_high_ticks);
                if (lnn_reg)
                begin
                    lnn_next = 1'b0;    // poll restarts at the high nibble
                end
            end
            PH_RD_E, PH_POLL_E:
            begin
                if (wait_reg > WAIT_W'(1))
                begin
                    wait_next = wait_reg - WAIT_W'(1);
                end
                else
                begin
                    asm_next   = sampled;
                    phase_next = (phase_reg == PH_RD_E) ? PH_RD_GAP : PH_POLL_GAP;
                end
            end
            PH_RD_GAP:
            begin
                if (!lnn_reg)
                begin
                    lnn_next   = 1'b1;
                    phase_next = PH_RD_E;
                    wait_next  = e_load(cfg_reg.e_high_ticks);
                end
                else if (kind_reg == REQ_DATA_RD)
                begin
                    held_next  = asm_reg;
                    lnn_next   = 1'b0;
                    phase_next = PH_POLL_E;
                    wait_next  = e_load(cfg_reg.e_high_ticks);
                end
                else
                begin
                    // status read: no busy poll afterwards
                    lnn_next           = 1'b0;
                    res_next.done_res  = 1'b1;
                    res_next.read_byte = asm_reg;
                    phase_next         = PH_IDLE;
                end
            end
            PH_POLL_GAP:
            begin
                if (!lnn_reg)
                begin
                    lnn_next   = 1'b1;
                    phase_next = PH_POLL_E;
                    wait_next  = e_load(cfg_reg.e_high_ticks);
                end
                else if ((asm_reg & BUSY_FLAG) != 8'h00)
                begin
                    lnn_next   = 1'b0;
                    phase_next = PH_POLL_E;
                    wait_next  = e_load(cfg_reg.e_high_ticks);
                end
                else
                begin
                    lnn_next = 1'b0;
                    if (kind_reg == REQ_POWERUP)
                    begin
                        pstep_next        = step_sel;
                        phase_next        = st.phase;
                        wait_next         = st.fin ? wait_reg : st.wait_cnt;
                        res_next.done_res = st.fin;
                        if (st.held_load)
                        begin
                            held_next = st.held;
                        end
                    end
                    else
                    begin
                        res_next.done_res  = 1'b1;
                        res_next.read_byte = (kind_reg == REQ_DATA_RD) ? held_reg : 8'h00;
                        phase_next         = PH_IDLE;
                    end
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase

        res_next.rejected = !res_next.ready_res && req_known;
    end

    always_comb
    begin
        if (req_fire)
        begin
            res_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            wait_reg      <= '0;
            held_reg      <= '0;
            asm_reg       <= '0;
            kind_reg      <= '0;
            pstep_reg     <= '0;
            lnn_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (req_fire)
            begin
                phase_reg <= phase_next;
                wait_reg  <= wait_next;
                held_reg  <= held_next;
                asm_reg   <= asm_next;
                kind_reg  <= kind_next;
                pstep_reg <= pstep_next;
                lnn_reg   <= lnn_next;
            end
        end
    end

    // Payload register, no reset needed
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            res_reg <= res_next;
        end
    end

    assign res.valid         = res_valid_reg;
    assign res.lcd_e         = res_reg.lcd_e;
    assign res.lcd_rs        = res_reg.lcd_rs;
    assign res.lcd_rw        = res_reg.lcd_rw;
    assign res.lcd_bus_drive = res_reg.lcd_bus_drive;
    assign res.lcd_bus_out   = res_reg.lcd_bus_out;
    assign res.ready_res     = res_reg.ready_res;
    assign res.done_res      = res_reg.done_res;
    assign res.read_byte     = res_reg.read_byte;
    assign res.rejected      = res_reg.rejected;

`ifndef SYNTHESIS
    // Done only comes out of a running sequence, never on an idle tick.
    a_done_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> !(res_reg.done_res && res_reg.ready_res))
        else $error("done flagged on an idle tick");

    // A reject is only possible while busy.
    a_reject_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> !(res_reg.rejected && res_reg.ready_res))
        else $error("request rejected while idle");

    // The bus is driven only during an E-high write nibble.
    a_drive_write: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.lcd_bus_drive) |-> (res_reg.lcd_e && !res_reg.lcd_rw))
        else $error("bus driven outside a write strobe");

    // A read byte is only reported with done.
    a_byte_with_done: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.read_byte != 8'h00) |-> res_reg.done_res)
        else $error("read byte without done");
`endif

endmodule
